// ===== rtl/apg_pkg.sv =====
// Shared constants, types and state codes of the angular proximity grouping block.
package apg_pkg;

  localparam int ID_W           = 16;
  localparam int GRP_W          = 6;
  localparam int COS_W          = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int MAX_BLOBS_DEF  = 64;
  localparam int COORD_BITS_DEF = 12;
  localparam logic [COS_W-1:0] COS_RESET = 16'd65177;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SUN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COS    = 3'd3;

  // Load strobes for the pair test unit
  typedef struct packed {
    logic ld_i;
    logic ld_j;
  } apg_pair_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ,
    S_DIFF,
    S_ROOT,
    S_STORE,
    S_LINIT,
    S_RDI,
    S_LATI,
    S_CHKJ,
    S_RDLA,
    S_RDLB,
    S_PAIR,
    S_DEC,
    S_SWRD,
    S_SWWR,
    S_DRD,
    S_DCHK,
    S_DRD2,
    S_DWAIT
  } apg_state_t;

endpackage

// ===== rtl/apg_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module apg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/apg_isqrt.sv =====
// Restoring integer square root, one result bit per cycle.
module apg_isqrt #(
  parameter int W = 12
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2*W-1:0] radicand,
  output logic           done,
  output logic [W-1:0]   root
);

  logic [2*W-1:0]         rad_r;
  logic [W:0]             rem_r;
  logic [W-1:0]           root_r;
  logic [$clog2(W+1)-1:0] cnt_r;
  logic                   busy_r;
  logic                   done_r;

  logic [W+2:0] rem_t;
  logic [W+2:0] trial;
  logic         fits;

  // one trial subtraction per step
  always_comb begin
    rem_t = {rem_r, rad_r[2*W-1:2*W-2]};
    trial = {1'b0, root_r, 2'b01};
    fits  = (rem_t >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == ($clog2(W+1))'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= ($clog2(W+1))'(W);
    end else if (busy_r) begin
      rad_r <= {rad_r[2*W-3:0], 2'b00};
      cnt_r <= cnt_r - 1'b1;
      if (fits) begin
        rem_r  <= rem_t[W:0] - trial[W:0];
        root_r <= {root_r[W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_t[W:0];
        root_r <= {root_r[W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/apg_pair.sv =====
// Neighbor test of two stored blobs: dot product against the scaled cosine threshold.
module apg_pair #(
  parameter int CB = 12
) (
  input  logic                   clk,
  input  apg_pkg::apg_pair_ctl_t ctl,
  input  logic [3*CB+1:0]        geo,
  input  logic [2*CB-1:0]        rr,
  input  logic [15:0]            cos_thr,
  output logic                   close
);

  import apg_pkg::*;

  localparam int SUM_W = 2*CB + 4;
  localparam int LHS_W = SUM_W + COS_W;
  localparam int RHS_W = 2*CB + COS_W;

  logic signed [CB:0]      xi_r, yi_r, xj_r, yj_r;
  logic [CB-1:0]           zi_r, zj_r;
  logic [RHS_W-1:0]        rhs_r;
  logic signed [2*CB+1:0]  px_r, py_r;
  logic [2*CB-1:0]         pz_r;
  logic                    close_r;

  logic signed [SUM_W-1:0] pz_ext;
  logic signed [SUM_W-1:0] dot;
  logic signed [LHS_W-1:0] lhs;
  logic signed [LHS_W-1:0] rhs_ext;

  // operand registers; the threshold is fixed when the outer blob loads
  always_ff @(posedge clk) begin
    if (ctl.ld_i) begin
      xi_r  <= geo[CB:0];
      yi_r  <= geo[2*CB+1:CB+1];
      zi_r  <= geo[3*CB+1:2*CB+2];
      rhs_r <= RHS_W'(rr) * RHS_W'(cos_thr);
    end
    if (ctl.ld_j) begin
      xj_r <= geo[CB:0];
      yj_r <= geo[2*CB+1:CB+1];
      zj_r <= geo[3*CB+1:2*CB+2];
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    px_r <= xi_r * xj_r;
    py_r <= yi_r * yj_r;
    pz_r <= zi_r * zj_r;
  end

  // stage 2: sum and compare
  always_comb begin
    pz_ext  = {{(SUM_W-2*CB){1'b0}}, pz_r};
    dot     = SUM_W'(px_r) + SUM_W'(py_r) + pz_ext;
    lhs     = {dot, {COS_W{1'b0}}};
    rhs_ext = {{(LHS_W-RHS_W){1'b0}}, rhs_r};
  end

  always_ff @(posedge clk) begin
    close_r <= (lhs >= rhs_ext);
  end

  assign close = close_r;

endmodule

// ===== rtl/angular_proximity_grouping.sv =====
// Angular proximity grouping: blob centers are loaded one item each and put on the visible
// hemisphere (x, y relative to the disc center, z from a bit-serial square root inside the
// disc, zero outside it). The item flagged last closes the set and holds off the input until
// its final result leaves: labels are set up, each of the n(n-1)/2 pairs is tested through
// the shared label and geometry memories, every merge relabels the set, and then one result
// per stored blob leaves in load order. The memory-bound pair loop sets the total for a full
// set before any merges.
module angular_proximity_grouping #(
  parameter int MAX_BLOBS  = apg_pkg::MAX_BLOBS_DEF,
  parameter int COORD_BITS = apg_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input items
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // in_tdata: blob_id, center_x, center_y (low to high)
  input  logic [((apg_pkg::ID_W+2*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                                 in_tlast,
  // result items
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_tdata: out_blob_id, group_number (low to high)
  output logic [23:0]                          out_tdata,
  output logic                                 out_tlast,
  // out_tuser: overflowed
  output logic                                 out_tuser,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [apg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [apg_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import apg_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int AW    = $clog2(MAX_BLOBS);
  localparam int CW    = $clog2(MAX_BLOBS + 1);
  localparam int GEO_W = 3*CB + 2;

  // configuration registers
  logic [CB-1:0]    sun_x_r, sun_y_r, radius_r;
  logic [COS_W-1:0] cos_r;
  logic [2*CB-1:0]  rr_r;

  // control state
  apg_state_t  state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic        out_valid_r, out_valid_nxt;

  // payload state
  logic [ID_W-1:0]  id_r, id_nxt;
  logic signed [CB:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic             last_r, last_nxt;
  logic [2*CB-1:0]  sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [CB-1:0]    z_r, z_nxt;
  logic [CW-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, grp_r, grp_nxt;
  logic [AW-1:0]    la_r, la_nxt, lb_r, lb_nxt, keep_r, keep_nxt, drop_r, drop_nxt;
  logic [ID_W-1:0]  out_id_r, out_id_nxt;
  logic [GRP_W-1:0] out_grp_r, out_grp_nxt;
  logic             out_last_r, out_last_nxt, out_ovf_r, out_ovf_nxt;

  // memory ports
  logic             geo_we, id_we, lab_we;
  logic [AW-1:0]    geo_raddr, lab_raddr, lab_waddr;
  logic [AW-1:0]    lab_wdata, lab_rdata;
  logic [GEO_W-1:0] geo_rdata;
  logic [ID_W-1:0]  id_rdata;

  // arithmetic helpers
  logic signed [2*CB+1:0] sqx_full, sqy_full;
  logic [2*CB:0]          ss;
  logic                   root_start, root_done;
  logic [CB-1:0]          root;
  apg_pair_ctl_t          pair_ctl;
  logic                   close;

  // configuration port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sun_x_r  <= '0;
      sun_y_r  <= '0;
      radius_r <= CB'(1);
      cos_r    <= COS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SUN_X:  sun_x_r  <= cfg_data[CB-1:0];
        CFG_SUN_Y:  sun_y_r  <= cfg_data[CB-1:0];
        CFG_RADIUS: radius_r <= cfg_data[CB-1:0];
        CFG_COS:    cos_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // squared radius follows the radius register in the next cycle
  always_ff @(posedge clk) begin
    rr_r <= radius_r * radius_r;
  end

  assign sqx_full = rx_r * rx_r;
  assign sqy_full = ry_r * ry_r;
  assign ss       = {1'b0, sqx_r} + {1'b0, sqy_r};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    id_nxt        = id_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    last_nxt      = last_r;
    sqx_nxt       = sqx_r;
    sqy_nxt       = sqy_r;
    z_nxt         = z_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    grp_nxt       = grp_r;
    la_nxt        = la_r;
    lb_nxt        = lb_r;
    keep_nxt      = keep_r;
    drop_nxt      = drop_r;
    out_id_nxt    = out_id_r;
    out_grp_nxt   = out_grp_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    in_tready     = 1'b0;
    geo_we        = 1'b0;
    id_we         = 1'b0;
    lab_we        = 1'b0;
    lab_waddr     = k_r[AW-1:0];
    lab_wdata     = k_r[AW-1:0];
    geo_raddr     = i_r[AW-1:0];
    lab_raddr     = i_r[AW-1:0];
    root_start    = 1'b0;
    pair_ctl      = '0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          id_nxt   = in_tdata[ID_W-1:0];
          rx_nxt   = $signed({1'b0, in_tdata[ID_W+CB-1:ID_W]}) - $signed({1'b0, sun_x_r});
          ry_nxt   = $signed({1'b0, in_tdata[ID_W+2*CB-1:ID_W+CB]})
                     - $signed({1'b0, sun_y_r});
          last_nxt = in_tlast;
          k_nxt    = '0;
          if (cnt_r == CW'(MAX_BLOBS)) begin
            // store full: drop the blob
            ovf_nxt   = 1'b1;
            state_nxt = in_tlast ? S_LINIT : S_IDLE;
          end else begin
            state_nxt = S_SQ;
          end
        end
      end
      S_SQ: begin
        sqx_nxt   = sqx_full[2*CB-1:0];
        sqy_nxt   = sqy_full[2*CB-1:0];
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        if (ss >= {1'b0, rr_r}) begin
          // outside the disc
          z_nxt     = '0;
          state_nxt = S_STORE;
        end else begin
          root_start = 1'b1;
          state_nxt  = S_ROOT;
        end
      end
      S_ROOT: begin
        if (root_done) begin
          z_nxt     = root;
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        geo_we    = 1'b1;
        id_we     = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        k_nxt     = '0;
        state_nxt = last_r ? S_LINIT : S_IDLE;
      end
      // every blob starts as its own group
      S_LINIT: begin
        lab_we = 1'b1;
        k_nxt  = k_r + 1'b1;
        if (k_r + 1'b1 >= cnt_r) begin
          i_nxt     = '0;
          state_nxt = S_RDI;
        end
      end
      S_RDI: begin
        state_nxt = S_LATI;
      end
      S_LATI: begin
        pair_ctl.ld_i = 1'b1;
        j_nxt         = i_r + 1'b1;
        state_nxt     = S_CHKJ;
      end
      S_CHKJ: begin
        geo_raddr = j_r[AW-1:0];
        if (j_r >= cnt_r) begin
          if (i_r + 1'b1 >= cnt_r) begin
            i_nxt     = '0;
            grp_nxt   = '0;
            state_nxt = S_DRD;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_RDI;
          end
        end else begin
          state_nxt = S_RDLA;
        end
      end
      S_RDLA: begin
        pair_ctl.ld_j = 1'b1;
        la_nxt        = lab_rdata;
        lab_raddr     = j_r[AW-1:0];
        state_nxt     = S_RDLB;
      end
      S_RDLB: begin
        lb_nxt    = lab_rdata;
        state_nxt = S_PAIR;
      end
      S_PAIR: begin
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (la_r != lb_r && close) begin
          keep_nxt  = (la_r < lb_r) ? la_r : lb_r;
          drop_nxt  = (la_r < lb_r) ? lb_r : la_r;
          k_nxt     = '0;
          state_nxt = S_SWRD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_CHKJ;
        end
      end
      // relabel sweep: drop becomes keep
      S_SWRD: begin
        lab_raddr = k_r[AW-1:0];
        state_nxt = S_SWWR;
      end
      S_SWWR: begin
        lab_wdata = keep_r;
        lab_we    = (lab_rdata == drop_r);
        k_nxt     = k_r + 1'b1;
        if (k_r + 1'b1 >= cnt_r) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_CHKJ;
        end else begin
          state_nxt = S_SWRD;
        end
      end
      // dense numbering; a group's root is its lowest index
      S_DRD: begin
        state_nxt = S_DCHK;
      end
      S_DCHK: begin
        lab_waddr    = i_r[AW-1:0];
        out_id_nxt   = id_rdata;
        out_last_nxt = (i_r + 1'b1 == cnt_r);
        out_ovf_nxt  = ovf_r;
        if (lab_rdata == i_r[AW-1:0]) begin
          lab_we        = 1'b1;
          lab_wdata     = grp_r[AW-1:0];
          grp_nxt       = grp_r + 1'b1;
          out_grp_nxt   = GRP_W'(grp_r[AW-1:0]);
          out_valid_nxt = 1'b1;
          state_nxt     = S_DWAIT;
        end else begin
          lab_raddr = lab_rdata;
          state_nxt = S_DRD2;
        end
      end
      S_DRD2: begin
        lab_waddr     = i_r[AW-1:0];
        lab_we        = 1'b1;
        lab_wdata     = lab_rdata;
        out_grp_nxt   = GRP_W'(lab_rdata);
        out_valid_nxt = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (i_r + 1'b1 >= cnt_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_DRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    last_r     <= last_nxt;
    sqx_r      <= sqx_nxt;
    sqy_r      <= sqy_nxt;
    z_r        <= z_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    grp_r      <= grp_nxt;
    la_r       <= la_nxt;
    lb_r       <= lb_nxt;
    keep_r     <= keep_nxt;
    drop_r     <= drop_nxt;
    out_id_r   <= out_id_nxt;
    out_grp_r  <= out_grp_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // blob depth
  apg_isqrt #(.W(CB)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (rr_r - ss[2*CB-1:0]),
    .done     (root_done),
    .root     (root)
  );

  // geometry store: {z, y, x}
  apg_ram #(.WIDTH(GEO_W), .DEPTH(MAX_BLOBS)) u_geo_ram (
    .clk   (clk),
    .we    (geo_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({z_r, ry_r, rx_r}),
    .raddr (geo_raddr),
    .rdata (geo_rdata)
  );

  apg_ram #(.WIDTH(ID_W), .DEPTH(MAX_BLOBS)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (id_r),
    .raddr (i_r[AW-1:0]),
    .rdata (id_rdata)
  );

  apg_ram #(.WIDTH(AW), .DEPTH(MAX_BLOBS)) u_lab_ram (
    .clk   (clk),
    .we    (lab_we),
    .waddr (lab_waddr),
    .wdata (lab_wdata),
    .raddr (lab_raddr),
    .rdata (lab_rdata)
  );

  apg_pair #(.CB(CB)) u_pair (
    .clk     (clk),
    .ctl     (pair_ctl),
    .geo     (geo_rdata),
    .rr      (rr_r),
    .cos_thr (cos_r),
    .close   (close)
  );

  // result port
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_grp_r, out_id_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

// ===== test/tb_top.sv =====
// Testbench of the angular proximity grouping block: directed and random blob sets, scoreboard.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import apg_pkg::*;

  localparam int NBLOB      = 64;
  localparam int DATA_W     = 40;
  localparam int CYCLE_CAP  = 1000000;
  localparam int SETTLE     = 200;
  localparam int HOLD_LEN   = 3000;

  typedef struct {
    logic [15:0] blob_id;
    logic [5:0]  group;
    logic        last_res;
    logic        ovf;
  } grouping_t;

  // Predictor of blob grouping plus the queue of expected group items
  class grouping_scoreboard;
    logic [11:0] cen_x, cen_y, radius;
    logic [15:0] cos_thr;
    logic [15:0] ids[NBLOB];
    longint      px[NBLOB], py[NBLOB], pz[NBLOB];
    int          count;
    bit          ovf;
    grouping_t   pending[$];
    int          errors;

    function new();
      cen_x = '0; cen_y = '0; radius = 12'd1; cos_thr = COS_RESET;
      count = 0; ovf = 0; errors = 0;
    endfunction

    function void report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_SUN_X:  cen_x = val[11:0];
        CFG_SUN_Y:  cen_y = val[11:0];
        CFG_RADIUS: radius = val[11:0];
        CFG_COS:    cos_thr = val;
        default: ;
      endcase
    endfunction

    // floor square root, bit by bit from the top
    function longint root_floor(longint v);
      longint acc, t;
      acc = 0;
      for (int b = 31; b >= 0; b--) begin
        t = acc | (longint'(1) << b);
        if (t * t <= v) acc = t;
      end
      return acc;
    endfunction

    function bit neighbors(int a, int b);
      longint dot, lim;
      dot = px[a] * px[b] + py[a] * py[b] + pz[a] * pz[b];
      lim = longint'(radius) * longint'(radius) * longint'(cos_thr);
      return dot * 65536 >= lim;
    endfunction

    function void note_blob(logic [15:0] id, logic [11:0] cx, logic [11:0] cy, logic lst);
      longint rr, ss;
      int comp[NBLOB];
      int dense[NBLOB];
      int ngrp;
      bit moved;
      grouping_t g;
      if (count < NBLOB) begin
        px[count] = longint'(cx) - longint'(cen_x);
        py[count] = longint'(cy) - longint'(cen_y);
        rr = longint'(radius) * longint'(radius);
        ss = px[count] * px[count] + py[count] * py[count];
        pz[count] = (ss >= rr) ? 0 : root_floor(rr - ss);
        ids[count] = id;
        count++;
      end else begin
        ovf = 1;
      end
      if (!lst) return;
      // components: spread the minimum index until nothing changes
      for (int i = 0; i < count; i++) comp[i] = i;
      do begin
        moved = 0;
        for (int i = 0; i < count; i++)
          for (int j = i + 1; j < count; j++)
            if (comp[i] != comp[j] && neighbors(i, j)) begin
              if (comp[i] < comp[j]) comp[j] = comp[i];
              else comp[i] = comp[j];
              moved = 1;
            end
      end while (moved);
      for (int i = 0; i < NBLOB; i++) dense[i] = -1;
      ngrp = 0;
      for (int i = 0; i < count; i++) begin
        if (dense[comp[i]] < 0) dense[comp[i]] = ngrp++;
        g.blob_id = ids[i];
        g.group = 6'(dense[comp[i]]);
        g.last_res = (i == count - 1);
        g.ovf = ovf;
        pending.insert(pending.size(), g);
      end
      count = 0;
      ovf = 0;
    endfunction

    function void check_result(logic [15:0] id, logic [5:0] grp, logic lr, logic ov);
      grouping_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected item id=%h grp=%0d", id, grp));
        return;
      end
      e = pending.pop_front();
      if (id !== e.blob_id) report($sformatf("blob_id %h, want %h", id, e.blob_id));
      if (grp !== e.group)
        report($sformatf("group %0d, want %0d (id %h)", grp, e.group, e.blob_id));
      if (lr !== e.last_res) report($sformatf("last %b, want %b (id %h)", lr, e.last_res, id));
      if (ov !== e.ovf) report($sformatf("overflow %b, want %b (id %h)", ov, e.ovf, id));
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_tvalid = 0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic              in_tlast = 0;
  logic              out_tvalid;
  logic              out_tready = 0;
  logic [23:0]       out_tdata;
  logic              out_tlast;
  logic              out_tuser;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  grouping_scoreboard sb = new();
  bit  hold_req = 0;
  bit  no_gaps = 0;
  int  cycles = 0;

  angular_proximity_grouping u_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // result sink: random stalls plus one long hold-off once results show up after the request
  int hold_cnt = 0;
  bit hold_done = 0;
  int stall_cnt = 0;
  always @(posedge clk) begin
    if (hold_req && !hold_done && out_tvalid) begin
      hold_done <= 1;
      hold_cnt <= HOLD_LEN;
      out_tready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= (hold_cnt == 1);
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_tready <= (stall_cnt == 1);
    end else begin
      stall_cnt <= gap_len();
      out_tready <= (gap_len() == 0) || no_gaps;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[15:0], out_tdata[21:16], out_tlast, out_tuser);
  end

  task send_blob(logic [15:0] id, logic [11:0] cx, logic [11:0] cy, logic lst);
    int g;
    in_tvalid <= 1;
    in_tdata  <= {cy, cx, id};
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    sb.note_blob(id, cx, cy, lst);
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // one register write; valid drops before the next write
  task write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task wait_idle();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task set_geometry(logic [11:0] cx, logic [11:0] cy, logic [11:0] r, logic [15:0] c);
    write_reg(CFG_SUN_X, {4'd0, cx});
    write_reg(CFG_SUN_Y, {4'd0, cy});
    write_reg(CFG_RADIUS, {4'd0, r});
    write_reg(CFG_COS, c);
  endtask

  function logic [11:0] near(int c, int spread);
    int v;
    v = c + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  // one well-formed set around a few cluster points, some noise
  task random_set(int n);
    int cxs[3], cys[3];
    int k;
    for (int c = 0; c < 3; c++) begin
      cxs[c] = int'(sb.cen_x) + int'($urandom_range(0, 2 * int'(sb.radius))) - int'(sb.radius);
      cys[c] = int'(sb.cen_y) + int'($urandom_range(0, 2 * int'(sb.radius))) - int'(sb.radius);
    end
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0)
        send_blob(16'($urandom), 12'($urandom), 12'($urandom), i == n - 1);
      else
        send_blob(16'($urandom), near(cxs[k], 60), near(cys[k], 60), i == n - 1);
    end
  endtask

  initial begin
    int sent;
    int nset;
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // extremes of position, identical ids, outside the disc, close neighbors
    set_geometry(12'd2048, 12'd2048, 12'd2000, COS_RESET);
    send_blob(16'h0000, 12'd2048, 12'd2048, 0);
    send_blob(16'hFFFF, 12'd2060, 12'd2050, 0);
    send_blob(16'hFFFF, 12'd0, 12'd0, 0);
    send_blob(16'h1234, 12'd4095, 12'd4095, 0);
    send_blob(16'h1234, 12'd4095, 12'd0, 0);
    send_blob(16'hA5A5, 12'd0, 12'd4095, 0);
    send_blob(16'h5A5A, 12'd3000, 12'd2048, 0);
    send_blob(16'h0F0F, 12'd3010, 12'd2060, 1);
    // single-blob set
    send_blob(16'h8001, 12'd100, 12'd200, 1);
    wait_idle();

    // geometry changed in the middle of a set, block idle between items
    send_blob(16'h0101, 12'd1500, 12'd1500, 0);
    wait_idle();
    write_reg(CFG_SUN_X, 16'd1000);
    write_reg(CFG_COS, 16'd60000);
    repeat (SETTLE) @(posedge clk);
    send_blob(16'h0202, 12'd1500, 12'd1500, 0);
    send_blob(16'h0303, 12'd1520, 12'd1500, 1);
    wait_idle();

    // zero radius and zero threshold
    set_geometry(12'd0, 12'd0, 12'd0, 16'd0);
    send_blob(16'h0001, 12'd5, 12'd5, 0);
    send_blob(16'h0002, 12'd4095, 12'd0, 0);
    send_blob(16'h0003, 12'd0, 12'd0, 1);
    wait_idle();
    // widest disc, strictest threshold
    set_geometry(12'd4095, 12'd0, 12'd4095, 16'hFFFF);
    send_blob(16'h0004, 12'd4095, 12'd0, 0);
    send_blob(16'h0005, 12'd4095, 12'd0, 0);
    send_blob(16'h0006, 12'd0, 12'd4095, 1);
    wait_idle();

    // random sets; one long sink hold-off while items keep coming, one overflowing set
    set_geometry(12'd2048, 12'd2048, 12'd1500, COS_RESET);
    sent = 0;
    nset = 0;
    while (sent < 100) begin
      if (nset % 4 == 3) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0: set_geometry(12'($urandom_range(1000, 3000)), 12'($urandom_range(1000, 3000)),
                          12'($urandom_range(300, 2000)), COS_RESET);
          1: set_geometry(12'($urandom_range(1000, 3000)), 12'($urandom_range(1000, 3000)),
                          12'($urandom_range(1, 4095)), 16'($urandom));
          2: write_reg(CFG_COS, 16'($urandom_range(64000, 65535)));
          default: write_reg(CFG_RADIUS, 16'($urandom_range(200, 1500)));
        endcase
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      if (nset == 4) hold_req = 1;
      if (nset == 5) begin
        random_set(66);
        sent += 66;
      end else begin
        n = $urandom_range(1, 12);
        random_set(n);
        sent += n;
      end
      nset++;
    end

    wait_idle();
    if (sb.errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
